// ===== hdl/wdc_pkg.sv =====
`timescale 1ns / 1ps

package wdc_pkg;

    // Default upper bound on a grid dimension
    localparam int DEF_MAX_DIM = 256;

    // Configuration port
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIM_X = 2'd0,
        REG_DIM_Y = 2'd1,
        REG_DIM_Z = 2'd2
    } t_cfg_reg;

    // Result field widths
    localparam int COORD_OUT_W = 8;
    localparam int DIAG_OUT_W  = 10;
    localparam int RANK_W      = 16;
    localparam int POINT_W     = 24;

    // One result item
    typedef struct packed {
        logic                   valid_res;
        logic [COORD_OUT_W-1:0] cell_x;
        logic [COORD_OUT_W-1:0] cell_y;
        logic [COORD_OUT_W-1:0] cell_z;
        logic [DIAG_OUT_W-1:0]  diag_index;
        logic [RANK_W-1:0]      rank_in_diag;
        logic [POINT_W-1:0]     point_index;
        logic [POINT_W-1:0]     diag_first;
        logic                   last_in_diag;
        logic                   last_point;
    } t_result;

    // Largest dimension reachable through a 9-bit register
    function automatic int eff_max(input int max_dim);
        int lim;
        lim = (1 << CFG_DATA_W) - 1;
        return (max_dim < lim) ? max_dim : lim;
    endfunction

    // Bits for a coordinate, 0 .. eff_max-1
    function automatic int coord_w(input int max_dim);
        return $clog2(eff_max(max_dim));
    endfunction

    // Bits for a diagonal index, 0 .. 3*(eff_max-1)
    function automatic int diag_w(input int max_dim);
        return $clog2(3 * (eff_max(max_dim) - 1) + 1);
    endfunction

endpackage

// ===== hdl/wavefront_diagonal_cell_order_unit.sv =====
`timescale 1ns / 1ps

// Walks the cells of a dim_x by dim_y by dim_z grid in wavefront order:
// by diagonal i+j+k, then by k, then by j. Every accepted item (restart or
// next) yields exactly one result item, registered for the next cycle; the
// cursor update is a few combinational adds and compares, so, unless the
// consumer stalls, the rate is one item per clock. Restart returns cell 0,0,0.
// After the last cell, results come back with valid_res low and all other
// fields zero until a restart. Dimension writes of 0 act as 1, values over
// MAX_DIM act as MAX_DIM, and any dimension write also rewinds the walk to
// cell 0,0,0. Write configuration only while no item is in flight.
module wavefront_diagonal_cell_order_unit import wdc_pkg::*; #(
    parameter  int MAX_DIM = DEF_MAX_DIM,
    localparam int CW      = coord_w(MAX_DIM),
    localparam int DW      = diag_w(MAX_DIM)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_restart,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_valid_res,
    output logic [COORD_OUT_W-1:0] o_cell_x,
    output logic [COORD_OUT_W-1:0] o_cell_y,
    output logic [COORD_OUT_W-1:0] o_cell_z,
    output logic [DIAG_OUT_W-1:0]  o_diag_index,
    output logic [RANK_W-1:0]      o_rank_in_diag,
    output logic [POINT_W-1:0]     o_point_index,
    output logic [POINT_W-1:0]     o_diag_first,
    output logic                   o_last_in_diag,
    output logic                   o_last_point
);

    logic [CW-1:0]      nx_m1, ny_m1, nz_m1;
    logic [DW-1:0]      last_diag;
    logic               cfg_hit;
    logic               in_accept;

    logic [DW-1:0]      r_diag, n_diag;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_j, n_j;
    logic [RANK_W-1:0]  r_rank, n_rank;
    logic [POINT_W-1:0] r_point, n_point;
    logic [POINT_W-1:0] r_base, n_base;
    logic               r_finished, n_finished;

    t_result            n_out;
    t_result            r_out;
    logic               r_out_valid;

    wdc_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_nx_m1     (nx_m1),
        .o_ny_m1     (ny_m1),
        .o_nz_m1     (nz_m1),
        .o_last_diag (last_diag),
        .o_cfg_hit   (cfg_hit)
    );

    wdc_step #(
        .MAX_DIM (MAX_DIM)
    ) u_step (
        .i_restart   (i_restart),
        .i_diag      (r_diag),
        .i_k         (r_k),
        .i_j         (r_j),
        .i_rank      (r_rank),
        .i_point     (r_point),
        .i_base      (r_base),
        .i_finished  (r_finished),
        .i_nx_m1     (nx_m1),
        .i_ny_m1     (ny_m1),
        .i_nz_m1     (nz_m1),
        .i_last_diag (last_diag),
        .o_result    (n_out),
        .o_diag      (n_diag),
        .o_k         (n_k),
        .o_j         (n_j),
        .o_rank      (n_rank),
        .o_point     (n_point),
        .o_base      (n_base),
        .o_finished  (n_finished)
    );

    // Stall only while a result waits and the consumer holds it
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Hold the cursor; rewind on a dimension write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag     <= '0;
            r_k        <= '0;
            r_j        <= '0;
            r_rank     <= '0;
            r_point    <= '0;
            r_base     <= '0;
            r_finished <= 1'b0;
        end else if (cfg_hit) begin
            r_diag     <= '0;
            r_k        <= '0;
            r_j        <= '0;
            r_rank     <= '0;
            r_point    <= '0;
            r_base     <= '0;
            r_finished <= 1'b0;
        end else if (in_accept) begin
            r_diag     <= n_diag;
            r_k        <= n_k;
            r_j        <= n_j;
            r_rank     <= n_rank;
            r_point    <= n_point;
            r_base     <= n_base;
            r_finished <= n_finished;
        end
    end

    // Result valid: set on accept, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_valid_res    = r_out.valid_res;
    assign o_cell_x       = r_out.cell_x;
    assign o_cell_y       = r_out.cell_y;
    assign o_cell_z       = r_out.cell_z;
    assign o_diag_index   = r_out.diag_index;
    assign o_rank_in_diag = r_out.rank_in_diag;
    assign o_point_index  = r_out.point_index;
    assign o_diag_first   = r_out.diag_first;
    assign o_last_in_diag = r_out.last_in_diag;
    assign o_last_point   = r_out.last_point;

endmodule

// ===== hdl/wdc_cfg.sv =====
`timescale 1ns / 1ps

module wdc_cfg import wdc_pkg::*; #(
    parameter  int MAX_DIM = DEF_MAX_DIM,
    localparam int CW      = coord_w(MAX_DIM),
    localparam int DW      = diag_w(MAX_DIM),
    localparam int EFF_MAX = eff_max(MAX_DIM)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [CW-1:0]          o_nx_m1,
    output logic [CW-1:0]          o_ny_m1,
    output logic [CW-1:0]          o_nz_m1,
    output logic [DW-1:0]          o_last_diag,
    output logic                   o_cfg_hit
);

    logic [CW-1:0] r_nx_m1;
    logic [CW-1:0] r_ny_m1;
    logic [CW-1:0] r_nz_m1;
    logic [CW-1:0] n_dim_m1;

    // Clamp the written dimension to 1 .. MAX_DIM and keep it minus one
    always_comb begin
        if (i_cfg_data == '0) begin
            n_dim_m1 = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_DIM)) begin
            n_dim_m1 = CW'(EFF_MAX - 1);
        end else begin
            n_dim_m1 = CW'(i_cfg_data - CFG_DATA_W'(1));
        end
    end

    // Hold the dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx_m1 <= '0;
            r_ny_m1 <= '0;
            r_nz_m1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DIM_X: r_nx_m1 <= n_dim_m1;
                REG_DIM_Y: r_ny_m1 <= n_dim_m1;
                REG_DIM_Z: r_nz_m1 <= n_dim_m1;
                default:   ;
            endcase
        end
    end

    // Flag a write that lands on a known register
    assign o_cfg_hit = i_cfg_we && (i_cfg_index == REG_DIM_X ||
                                    i_cfg_index == REG_DIM_Y ||
                                    i_cfg_index == REG_DIM_Z);

    assign o_nx_m1     = r_nx_m1;
    assign o_ny_m1     = r_ny_m1;
    assign o_nz_m1     = r_nz_m1;
    assign o_last_diag = DW'(r_nx_m1) + DW'(r_ny_m1) + DW'(r_nz_m1);

endmodule

// ===== hdl/wdc_step.sv =====
`timescale 1ns / 1ps

module wdc_step import wdc_pkg::*; #(
    parameter  int MAX_DIM = DEF_MAX_DIM,
    localparam int CW      = coord_w(MAX_DIM),
    localparam int DW      = diag_w(MAX_DIM)
) (
    input  logic               i_restart,
    input  logic [DW-1:0]      i_diag,
    input  logic [CW-1:0]      i_k,
    input  logic [CW-1:0]      i_j,
    input  logic [RANK_W-1:0]  i_rank,
    input  logic [POINT_W-1:0] i_point,
    input  logic [POINT_W-1:0] i_base,
    input  logic               i_finished,
    input  logic [CW-1:0]      i_nx_m1,
    input  logic [CW-1:0]      i_ny_m1,
    input  logic [CW-1:0]      i_nz_m1,
    input  logic [DW-1:0]      i_last_diag,
    output t_result            o_result,
    output logic [DW-1:0]      o_diag,
    output logic [CW-1:0]      o_k,
    output logic [CW-1:0]      o_j,
    output logic [RANK_W-1:0]  o_rank,
    output logic [POINT_W-1:0] o_point,
    output logic [POINT_W-1:0] o_base,
    output logic               o_finished
);

    localparam int SW = DW + 2;

    logic [DW-1:0]      diag;
    logic [CW-1:0]      kk;
    logic [CW-1:0]      jj;
    logic [RANK_W-1:0]  rank;
    logic [POINT_W-1:0] point;
    logic [POINT_W-1:0] base;
    logic               done;
    logic [POINT_W-1:0] point_inc;

    logic signed [SW-1:0] s_d, s_k, s_j, s_nx, s_ny, s_nz;
    logic signed [SW-1:0] s_jmax, s_kmax, s_x;
    logic signed [SW-1:0] s_k1, s_jk, s_d1, s_kn, s_jn;
    logic signed [SW-1:0] raw_jk, raw_kn, raw_jn;
    logic                 j_more, k_more, end_diag, end_grid;

    // Drop back to cell 0,0,0 on restart
    always_comb begin
        diag  = i_restart ? '0 : i_diag;
        kk    = i_restart ? '0 : i_k;
        jj    = i_restart ? '0 : i_j;
        rank  = i_restart ? '0 : i_rank;
        point = i_restart ? '0 : i_point;
        base  = i_restart ? '0 : i_base;
        done  = i_restart ? 1'b0 : i_finished;
    end

    // Bounds of the current diagonal and the candidate next cells
    always_comb begin
        s_d  = $signed(SW'(diag));
        s_k  = $signed(SW'(kk));
        s_j  = $signed(SW'(jj));
        s_nx = $signed(SW'(i_nx_m1));
        s_ny = $signed(SW'(i_ny_m1));
        s_nz = $signed(SW'(i_nz_m1));

        s_x    = s_d - s_j - s_k;
        s_jmax = (s_ny < s_x + s_j) ? s_ny : s_x + s_j;
        s_kmax = (s_nz < s_d) ? s_nz : s_d;
        j_more = s_j < s_jmax;
        k_more = s_k < s_kmax;
        end_diag = !j_more && !k_more;
        end_grid = end_diag && (diag == i_last_diag);

        // next k within the diagonal
        s_k1   = s_k + SW'(1);
        raw_jk = s_d - s_k1 - s_nx;
        s_jk   = (raw_jk < 0) ? '0 : raw_jk;

        // first cell of the next diagonal
        s_d1   = s_d + SW'(1);
        raw_kn = s_d1 - s_nx - s_ny;
        s_kn   = (raw_kn < 0) ? '0 : raw_kn;
        raw_jn = s_d1 - s_kn - s_nx;
        s_jn   = (raw_jn < 0) ? '0 : raw_jn;
    end

    assign point_inc = point + POINT_W'(1);

    // Build the result item
    always_comb begin
        o_result = '0;
        if (!done) begin
            o_result.valid_res    = 1'b1;
            o_result.cell_x       = COORD_OUT_W'(s_x);
            o_result.cell_y       = COORD_OUT_W'(jj);
            o_result.cell_z       = COORD_OUT_W'(kk);
            o_result.diag_index   = DIAG_OUT_W'(diag);
            o_result.rank_in_diag = rank;
            o_result.point_index  = point;
            o_result.diag_first   = base;
            o_result.last_in_diag = end_diag;
            o_result.last_point   = end_grid;
        end
    end

    // Advance the cursor
    always_comb begin
        o_diag     = diag;
        o_k        = kk;
        o_j        = jj;
        o_rank     = rank;
        o_point    = point;
        o_base     = base;
        o_finished = done;
        if (!done) begin
            o_point = point_inc;
            if (j_more) begin
                o_j    = jj + CW'(1);
                o_rank = rank + RANK_W'(1);
            end else if (k_more) begin
                o_k    = CW'(s_k1);
                o_j    = CW'(s_jk);
                o_rank = rank + RANK_W'(1);
            end else if (end_grid) begin
                o_finished = 1'b1;
            end else begin
                o_diag = DW'(s_d1);
                o_k    = CW'(s_kn);
                o_j    = CW'(s_jn);
                o_rank = '0;
                o_base = point_inc;
            end
        end
    end

endmodule
